// ===== src/simd_pkg.sv =====
// Package for the signed integer multiply/divide unit.
// Holds opcodes, status codes and the work descriptor type; no dependencies.
package simd_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 7;

  typedef enum logic [2:0] {
    OP_INC    = 3'd0,
    OP_DEC    = 3'd1,
    OP_MUL32  = 3'd2,
    OP_DIV32  = 3'd3,
    OP_MUL64  = 3'd4,
    OP_DIV64  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  // Work descriptor handed from the front part to the back part.
  typedef struct packed {
    logic              is_mul;   // iterative multiply needed
    logic              is_div;   // iterative divide needed
    logic              neg_q;    // negate quotient
    logic              neg_r;    // negate remainder
    logic [DataW-1:0]  a;        // multiplicand or dividend magnitude
    logic [DataW-1:0]  b;        // multiplier or divisor magnitude
    logic [DataW-1:0]  lo;       // ready result for simple cases
    logic [DataW-1:0]  hi;
    logic [1:0]        status;
    logic              neg_p;    // negate product
    logic              zero_hi;  // 32-bit multiply returns a zero high word
  } work_t;

endpackage

// ===== src/simd_front.sv =====
// Front part: accepts items, classifies them and prepares operand magnitudes.
// Depends on simd_pkg.
module simd_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_opcode,
  input  logic signed [63:0]        in_operand_a,
  input  logic signed [63:0]        in_operand_b,
  output logic                      wr_valid,
  input  logic                      wr_full,
  output simd_pkg::work_t           wr_work
);

  logic [63:0]     a_ext;
  logic [63:0]     b_ext;
  logic [63:0]     minval;
  logic            a_neg;
  logic            b_neg;
  logic            is32;
  simd_pkg::work_t w;

  assign in_stall = wr_full;
  assign wr_valid = in_valid;
  assign wr_work  = w;

  // Classify the item and precompute special-case results.
  always_comb begin
    is32   = (in_opcode == simd_pkg::OP_MUL32) || (in_opcode == simd_pkg::OP_DIV32);
    a_ext  = is32 ? {{32{in_operand_a[31]}}, in_operand_a[31:0]} : in_operand_a;
    b_ext  = is32 ? {{32{in_operand_b[31]}}, in_operand_b[31:0]} : in_operand_b;
    minval = is32 ? {{33{1'b1}}, 31'd0} : {1'b1, 63'd0};
    a_neg  = a_ext[63];
    b_neg  = b_ext[63];
    w        = '0;
    w.a      = a_neg ? (64'd0 - a_ext) : a_ext;
    w.b      = b_neg ? (64'd0 - b_ext) : b_ext;
    w.neg_p  = a_neg ^ b_neg;
    w.neg_q  = a_neg ^ b_neg;
    w.neg_r  = a_neg;
    w.zero_hi = (in_opcode == simd_pkg::OP_MUL32);
    case (in_opcode)
      simd_pkg::OP_INC: w.lo = in_operand_a + 64'd1;
      simd_pkg::OP_DEC: w.lo = in_operand_a - 64'd1;
      simd_pkg::OP_MUL32, simd_pkg::OP_MUL64: w.is_mul = 1'b1;
      simd_pkg::OP_DIV32, simd_pkg::OP_DIV64: begin
        if (b_ext == 64'd0) begin
          w.lo     = '1;
          w.hi     = a_ext;
          w.status = simd_pkg::ST_DIV0;
        end else if (a_ext == minval && b_ext == '1) begin
          w.lo     = minval;
          w.status = simd_pkg::ST_OVF;
        end else begin
          w.is_div = 1'b1;
        end
      end
      default: w.lo = '0;
    endcase
  end

endmodule

// ===== src/simd_queue.sv =====
// Two-entry queue of work descriptors between the front and back parts.
// Depends on simd_pkg.
module simd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_full,
  input  simd_pkg::work_t wr_work,
  output logic            rd_valid,
  input  logic            rd_take,
  output simd_pkg::work_t rd_work
);

  simd_pkg::work_t mem_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            pop;

  assign wr_full  = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_work  = mem_r[rp_r];
  assign push     = wr_valid && !wr_full;
  assign pop      = rd_take && rd_valid;

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_work;
  end

endmodule

// ===== src/simd_back.sv =====
// Back part: iterative shift-add multiply and restoring divide, one bit a cycle.
// Depends on simd_pkg.
module simd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_valid,
  output logic                rd_take,
  input  simd_pkg::work_t     rd_work,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [63:0]  out_result_low,
  output logic signed [63:0]  out_result_high,
  output logic [1:0]          out_status
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIX} state_t;

  state_t                    state_r;
  logic [simd_pkg::CntW-1:0] cnt_r;
  logic [63:0]               acc_r;   // product high / partial remainder
  logic [63:0]               sh_r;    // multiplier / dividend-quotient shift
  logic [63:0]               b_r;
  logic                      neg_q_r;
  logic                      neg_r_r;
  logic                      div_mode_r;
  logic                      zero_hi_r;
  logic                      out_valid_r;
  logic [63:0]               lo_r;
  logic [63:0]               hi_r;
  logic [1:0]                st_r;
  logic [64:0]               madd;
  logic [64:0]               rsh;
  logic [64:0]               dsub;
  logic [127:0]              prod;
  logic                      out_free;
  logic                      simple_take;
  logic                      fix_done;

  assign out_free        = !out_valid_r || !out_stall;
  assign rd_take         = (state_r == S_IDLE) && rd_valid && out_free;
  assign simple_take     = rd_take && !rd_work.is_mul && !rd_work.is_div;
  assign fix_done        = (state_r == S_FIX) && out_free;
  assign out_valid       = out_valid_r;
  assign out_result_low  = lo_r;
  assign out_result_high = hi_r;
  assign out_status      = st_r;

  // Datapath step helpers.
  always_comb begin
    madd = {1'b0, acc_r} + (sh_r[0] ? {1'b0, b_r} : 65'd0);
    rsh  = {acc_r, sh_r[63]};
    dsub = rsh - {1'b0, b_r};
    prod = neg_q_r ? (128'd0 - {acc_r, sh_r}) : {acc_r, sh_r};
  end

  // Sequencer with registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // Result register: loaded by a finished item, freed when taken.
      if (simple_take || fix_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (rd_take) begin
            acc_r      <= '0;
            sh_r       <= rd_work.a;
            b_r        <= rd_work.b;
            neg_q_r    <= rd_work.is_mul ? rd_work.neg_p : rd_work.neg_q;
            neg_r_r    <= rd_work.neg_r;
            div_mode_r <= rd_work.is_div;
            zero_hi_r  <= rd_work.zero_hi;
            cnt_r      <= '0;
            if (rd_work.is_mul) begin
              state_r <= S_MUL;
            end else if (rd_work.is_div) begin
              state_r <= S_DIV;
            end else begin
              lo_r <= rd_work.lo;
              hi_r <= rd_work.hi;
              st_r <= rd_work.status;
            end
          end
        end
        S_MUL: begin
          {acc_r, sh_r} <= {madd, sh_r[63:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == simd_pkg::CntW'(simd_pkg::DataW - 1)) state_r <= S_FIX;
        end
        S_DIV: begin
          if (!dsub[64]) begin
            acc_r <= dsub[63:0];
            sh_r  <= {sh_r[62:0], 1'b1};
          end else begin
            acc_r <= rsh[63:0];
            sh_r  <= {sh_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == simd_pkg::CntW'(simd_pkg::DataW - 1)) state_r <= S_FIX;
        end
        S_FIX: begin
          if (out_free) begin
            st_r    <= simd_pkg::ST_OK;
            state_r <= S_IDLE;
            // Divide results use separate sign handling for quotient and remainder.
            if (div_mode_r) begin
              lo_r <= neg_q_r ? (64'd0 - sh_r) : sh_r;
              hi_r <= neg_r_r ? (64'd0 - acc_r) : acc_r;
            end else begin
              lo_r <= prod[63:0];
              hi_r <= zero_hi_r ? 64'd0 : prod[127:64];
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/signed_int_mul_div_unit.sv =====
// Signed integer multiply/divide unit, top level.
// Inc, dec and special divide cases go from the queue straight into the result register;
// multiply and divide run 64 one-bit steps in the back part, which takes no new item
// meanwhile. Simple items pass one a cycle while the output is not stalled.
// Reset (rst_n, synchronous) empties the queue and returns the back part to idle.
module signed_int_mul_div_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_low,
  output logic signed [63:0] out_result_high,
  output logic [1:0]         out_status
);

  logic            wr_valid;
  logic            wr_full;
  simd_pkg::work_t wr_work;
  logic            rd_valid;
  logic            rd_take;
  simd_pkg::work_t rd_work;

  simd_front u_front (
    .in_valid, .in_stall, .in_opcode, .in_operand_a, .in_operand_b,
    .wr_valid, .wr_full, .wr_work
  );

  simd_queue u_queue (
    .clk, .rst_n, .wr_valid, .wr_full, .wr_work, .rd_valid, .rd_take, .rd_work
  );

  simd_back u_back (
    .clk, .rst_n, .rd_valid, .rd_take, .rd_work, .out_valid, .out_stall,
    .out_result_low, .out_result_high, .out_status
  );

`ifndef SYNTH
  // A taken descriptor always comes from a non-empty queue.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    rd_take |-> rd_valid) else $error("back part took from empty queue");
  // A full queue stalls the input side.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    wr_full |-> in_stall) else $error("queue full without input stall");
  // Status is never the unused code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("bad status code");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the signed integer multiply/divide unit.
// Drives opcode/operand items, predicts each result in a local model and
// compares it field by field; depends on simd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [1:0]  st;
  } mdu_result_t;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Min64   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Max64   = 64'h7FFF_FFFF_FFFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_opcode;
  logic signed [63:0] in_operand_a;
  logic signed [63:0] in_operand_b;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] out_result_low;
  logic signed [63:0] out_result_high;
  logic [1:0]         out_status;

  mdu_result_t pending_results[$];
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_cycles;

  signed_int_mul_div_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_low(out_result_low), .out_result_high(out_result_high),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sign-extends the low 32 bits of a word.
  function automatic logic [63:0] ext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Truncating signed divide of already extended operands.
  function automatic mdu_result_t signed_divide(input logic [63:0] a,
                                                input logic [63:0] b,
                                                input logic [63:0] minval);
    mdu_result_t r;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] uq;
    logic [63:0] ur;
    r = '0;
    if (b == 64'd0) begin
      r.lo = AllOnes;
      r.hi = a;
      r.st = simd_pkg::ST_DIV0;
    end else if (a == minval && b == AllOnes) begin
      r.lo = minval;
      r.hi = 64'd0;
      r.st = simd_pkg::ST_OVF;
    end else begin
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      uq = ua / ub;
      ur = ua % ub;
      r.lo = (a[63] != b[63]) ? -uq : uq;
      r.hi = a[63] ? -ur : ur;
      r.st = simd_pkg::ST_OK;
    end
    return r;
  endfunction

  // Expected result of one item.
  function automatic mdu_result_t mdu_predict(input logic [2:0] op,
                                              input logic [63:0] a,
                                              input logic [63:0] b);
    mdu_result_t r;
    logic signed [127:0] prod;
    r = '0;
    case (op)
      simd_pkg::OP_INC: r.lo = a + 64'd1;
      simd_pkg::OP_DEC: r.lo = a - 64'd1;
      simd_pkg::OP_MUL32: begin
        prod = $signed(ext32(a)) * $signed(ext32(b));
        r.lo = prod[63:0];
      end
      simd_pkg::OP_DIV32: r = signed_divide(ext32(a), ext32(b), ext32(64'h8000_0000));
      simd_pkg::OP_MUL64: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        r.lo = prod[63:0];
        r.hi = prod[127:64];
      end
      simd_pkg::OP_DIV64: r = signed_divide(a, b, Min64);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Sends one item, holding it until accepted; valid stays high for a
  // following item unless the sender idles.
  task automatic send_item(input logic [2:0] op, input logic [63:0] a,
                           input logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(mdu_predict(op, a, b));
    items_sent++;
    @(negedge clk);
  endtask

  // Receiver stall: random, or a counted long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    mdu_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result lo=%h hi=%h st=%0d", $time,
                 out_result_low, out_result_high, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_low !== want.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, want.lo,
                   out_result_low);
          error_count++;
        end
        if (out_result_high !== want.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, want.hi,
                   out_result_high);
          error_count++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st,
                   out_status);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand with a bias toward edge values and short magnitudes.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = Min64;
      1: v = Max64;
      2: v = AllOnes;
      3: v = 64'd0;
      4: v = ext32({32'd0, $urandom()});
      5: v = {{48{$urandom_range(1) == 1}}, 16'($urandom())};
      6: v = ext32({32'd0, 32'h8000_0000});
      default: v = rand64();
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  // Directed extremes and the special divide cases.
  task automatic test_directed();
    send_item(simd_pkg::OP_INC, Max64, 64'd0);
    send_item(simd_pkg::OP_INC, AllOnes, 64'd5);
    send_item(simd_pkg::OP_DEC, Min64, 64'd0);
    send_item(simd_pkg::OP_DEC, 64'd0, AllOnes);
    send_item(simd_pkg::OP_MUL32, 64'hFFFF_FFFF_8000_0000, 64'h0000_0000_8000_0000);
    send_item(simd_pkg::OP_MUL32, 64'h1234_5678_7FFF_FFFF, 64'h7FFF_FFFF);
    send_item(simd_pkg::OP_MUL64, Min64, Min64);
    send_item(simd_pkg::OP_MUL64, Max64, AllOnes);
    send_item(simd_pkg::OP_MUL64, Max64, Max64);
    send_item(simd_pkg::OP_DIV32, 64'd7, 64'd0);
    send_item(simd_pkg::OP_DIV32, 64'h0000_0000_8000_0000, AllOnes);
    send_item(simd_pkg::OP_DIV32, -64'sd7, 64'd2);
    send_item(simd_pkg::OP_DIV32, 64'd7, 64'hFFFF_FFFF_0000_0000);
    send_item(simd_pkg::OP_DIV64, Min64, AllOnes);
    send_item(simd_pkg::OP_DIV64, Min64, 64'd0);
    send_item(simd_pkg::OP_DIV64, -64'sd7, -64'sd2);
    send_item(simd_pkg::OP_DIV64, Max64, Min64);
    send_item(simd_pkg::OP_DIV64, Min64, Min64);
    send_item(3'd6, Max64, AllOnes);
    send_item(3'd7, AllOnes, AllOnes);
    wait_drained();
  endtask

  // Random items in one phase of sender idling and receiver stalling.
  task automatic test_random(input int count, input int idle, input int stall);
    logic [2:0] op;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                     : 3'($urandom_range(5));
      send_item(op, pick_operand(), pick_operand());
    end
    wait_drained();
  endtask

  // Receiver holds off long while the sender keeps offering items.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 600;
    for (int i = 0; i < 12; i++) send_item(3'($urandom_range(1)), rand64(), rand64());
    for (int i = 0; i < 6; i++) send_item(simd_pkg::OP_DIV64, rand64(), rand64());
    wait_drained();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_operand_a  = '0;
    in_operand_b  = '0;
    out_stall     = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    results_seen  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(370, 0, 0);
    test_random(370, 57, 0);
    test_random(370, 0, 57);
    test_random(370, 8, 8);
    test_backpressure();

    $display("Covered %0d items (%0d results) over all six operations, unused codes,",
             items_sent, results_seen);
    $display("divide by zero, divide overflow, idle and stall phases and a long hold-off.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #20ms;
    $display("Timeout reached");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== signed_int_mul_div_unit.f =====
src/simd_pkg.sv
src/simd_front.sv
src/simd_queue.sv
src/simd_back.sv
src/signed_int_mul_div_unit.sv
tb/testbench.sv
